@@ rtl/largest_valid_square_finder_unit_assert.svh @@
// assertion macros for the largest valid square finder
`ifndef LARGEST_VALID_SQUARE_FINDER_UNIT_ASSERT_SVH
`define LARGEST_VALID_SQUARE_FINDER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LVSF_ASSERT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LVSF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lvsf_pkg.sv @@
// shared types and constants for the largest valid square finder
package lvsf_pkg;

    // field widths
    localparam int GRAY_W      = 8;
    localparam int SIDE_W      = 12;
    localparam int COORD_W     = 11;
    localparam int CFG_DIM_W   = 12;
    localparam int CFG_THR_W   = 8;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELD_W = 1 + COORD_W + COORD_W + SIDE_W;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // reset values of the registers
    localparam int RST_FRAME_WIDTH  = 640;
    localparam int RST_FRAME_HEIGHT = 480;
    localparam logic [CFG_THR_W-1:0] RST_THRESHOLD = 8'd1;
    localparam logic [SIDE_W-1:0]    RST_MIN_SIDE  = 12'd20;

    // saturation value of a square side
    localparam logic [SIDE_W-1:0] SIDE_SAT = {SIDE_W{1'b1}};

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH     = 2'd0,
        CFG_FRAME_HEIGHT    = 2'd1,
        CFG_VALID_THRESHOLD = 2'd2,
        CFG_MIN_SIDE        = 2'd3
    } t_cfg_idx;

    // per-pixel flags handed from the scan stage to the update stage
    typedef struct packed {
        logic pix_ok;     // gray value above threshold
        logic on_border;  // first row or first column
        logic frame_end;  // last pixel of the frame
    } t_pix_flags;

endpackage

@@ rtl/lvsf_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module lvsf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data registered from the address
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/lvsf_cfg.sv @@
// configuration registers with frame size clamping
module lvsf_cfg
    import lvsf_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [CFG_IDX_W-1:0]             i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]            i_cfg_wdata,
    output logic [$clog2(MAX_WIDTH):0]       o_width,
    output logic [$clog2(MAX_HEIGHT):0]      o_height,
    output logic [CFG_THR_W-1:0]             o_threshold,
    output logic [SIDE_W-1:0]                o_min_side
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int XYW = (XW > YW) ? XW : YW;
    localparam int CMP_W = ((XYW > CFG_DIM_W) ? XYW : CFG_DIM_W) + 1;
    localparam int RST_W = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
    localparam int RST_H = (RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_HEIGHT;

    logic [XW:0]          r_width;
    logic [YW:0]          r_height;
    logic [CFG_THR_W-1:0] r_threshold;
    logic [SIDE_W-1:0]    r_min_side;
    logic [CMP_W-1:0]     dim_in;
    logic [XW:0]          n_width;
    logic [YW:0]          n_height;

    // zero acts as one, above the maximum acts as the maximum
    assign dim_in = CMP_W'(i_cfg_wdata[CFG_DIM_W-1:0]);

    always_comb begin
        if (dim_in == '0) begin
            n_width = (XW+1)'(1);
        end else if (dim_in > CMP_W'(MAX_WIDTH)) begin
            n_width = (XW+1)'(MAX_WIDTH);
        end else begin
            n_width = dim_in[XW:0];
        end
        if (dim_in == '0) begin
            n_height = (YW+1)'(1);
        end else if (dim_in > CMP_W'(MAX_HEIGHT)) begin
            n_height = (YW+1)'(MAX_HEIGHT);
        end else begin
            n_height = dim_in[YW:0];
        end
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= (XW+1)'(RST_W);
            r_height    <= (YW+1)'(RST_H);
            r_threshold <= RST_THRESHOLD;
            r_min_side  <= RST_MIN_SIDE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_WIDTH: begin
                    r_width <= n_width;
                end
                CFG_FRAME_HEIGHT: begin
                    r_height <= n_height;
                end
                CFG_VALID_THRESHOLD: begin
                    r_threshold <= i_cfg_wdata[CFG_THR_W-1:0];
                end
                CFG_MIN_SIDE: begin
                    r_min_side <= i_cfg_wdata[SIDE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_width     = r_width;
    assign o_height    = r_height;
    assign o_threshold = r_threshold;
    assign o_min_side  = r_min_side;

endmodule

@@ rtl/lvsf_scan.sv @@
// raster counters, pixel test and the line buffer read request
module lvsf_scan
    import lvsf_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_pix_valid,
    output logic                          o_pix_ready,
    input  logic [GRAY_W-1:0]             i_pix_gray,
    input  logic [$clog2(MAX_WIDTH):0]    i_width,
    input  logic [$clog2(MAX_HEIGHT):0]   i_height,
    input  logic [CFG_THR_W-1:0]          i_threshold,
    input  logic                          i_stall,
    output logic                          o_rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_rd_addr,
    output logic                          o_valid,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_col,
    output logic [$clog2(MAX_HEIGHT)-1:0] o_row,
    output t_pix_flags                    o_flags
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    logic          r_valid;
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;
    logic [XW-1:0] r_s1_col;
    logic [YW-1:0] r_s1_row;
    t_pix_flags    r_s1_flags;
    logic          accept;
    logic          row_end;
    logic          frame_end;
    logic [XW-1:0] n_col;
    logic [YW-1:0] n_row;
    t_pix_flags    n_flags;

    assign o_pix_ready = !i_stall;
    assign accept      = i_pix_valid && !i_stall;

    // end of row and end of frame against the current geometry
    assign row_end   = ({1'b0, r_col} + (XW+1)'(1)) >= i_width;
    assign frame_end = row_end && (({1'b0, r_row} + (YW+1)'(1)) >= i_height);

    always_comb begin
        n_col = row_end ? '0 : r_col + XW'(1);
        if (frame_end) begin
            n_row = '0;
        end else if (row_end) begin
            n_row = r_row + YW'(1);
        end else begin
            n_row = r_row;
        end
        n_flags.pix_ok    = i_pix_gray > i_threshold;
        n_flags.on_border = (r_row == '0) || (r_col == '0);
        n_flags.frame_end = frame_end;
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage register towards the update stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col   <= r_col;
            r_s1_row   <= r_row;
            r_s1_flags <= n_flags;
        end
    end

    assign o_rd_en   = accept;
    assign o_rd_addr = r_col;
    assign o_valid   = r_valid;
    assign o_col     = r_s1_col;
    assign o_row     = r_s1_row;
    assign o_flags   = r_s1_flags;

endmodule

@@ rtl/lvsf_lbuf.sv @@
// line buffer of previous-row sides with forwarding and fill tracking
module lvsf_lbuf
    import lvsf_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  logic [SIDE_W-1:0]            i_wr_data,
    output logic [SIDE_W-1:0]            o_up
);

    localparam int XW = $clog2(MAX_WIDTH);

    logic [XW:0]         r_fill;
    logic                r_hit;
    logic                r_known;
    logic [SIDE_W-1:0]   r_fwd;
    logic [SIDE_W-1:0]   ram_q;

    lvsf_ram #(
        .WIDTH (SIDE_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    // columns are written from zero upwards, so written entries form a prefix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_wr_en && ({1'b0, i_wr_addr} == r_fill)) begin
            r_fill <= r_fill + (XW+1)'(1);
        end
    end

    // same-entry write in the read cycle, and never-written entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit   <= 1'b0;
            r_known <= 1'b0;
        end else if (i_rd_en) begin
            r_hit   <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_known <= {1'b0, i_rd_addr} < r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd <= i_wr_data;
        end
    end

    assign o_up = r_hit ? r_fwd : (r_known ? ram_q : '0);

endmodule

@@ rtl/lvsf_dp.sv @@
// side update, best square tracking and the result register
module lvsf_dp
    import lvsf_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_col,
    input  logic [$clog2(MAX_HEIGHT)-1:0] i_row,
    input  t_pix_flags                    i_flags,
    input  logic [SIDE_W-1:0]             i_up,
    input  logic [SIDE_W-1:0]             i_min_side,
    output logic                          o_stall,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_wr_addr,
    output logic [SIDE_W-1:0]             o_wr_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_found,
    output logic [COORD_W-1:0]            o_left_x,
    output logic [COORD_W-1:0]            o_top_y,
    output logic [SIDE_W-1:0]             o_side
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int XYW = (XW > YW) ? XW : YW;
    localparam int PW  = ((XYW > SIDE_W) ? XYW : SIDE_W) + 1;

    logic [SIDE_W-1:0]  r_left;
    logic [SIDE_W-1:0]  r_up_left;
    logic [SIDE_W-1:0]  r_best;
    logic [XW-1:0]      r_best_col;
    logic [YW-1:0]      r_best_row;
    logic               r_out_valid;
    logic               r_found;
    logic [COORD_W-1:0] r_left_x;
    logic [COORD_W-1:0] r_top_y;
    logic [SIDE_W-1:0]  r_side;

    logic               fire;
    logic [SIDE_W-1:0]  min_a;
    logic [SIDE_W-1:0]  min_b;
    logic [SIDE_W-1:0]  cur;
    logic               better;
    logic [SIDE_W-1:0]  n_best;
    logic [XW-1:0]      n_best_col;
    logic [YW-1:0]      n_best_row;
    logic               n_found;
    logic [PW-1:0]      left_calc;
    logic [PW-1:0]      top_calc;

    // hold the frame's last pixel while the previous result is not taken
    assign o_stall = i_valid && i_flags.frame_end && r_out_valid && !i_out_ready;
    assign fire    = i_valid && !o_stall;

    // one plus the smallest neighbour, saturating; zero for a failing pixel, one on the border
    always_comb begin
        min_a = (i_up < r_left) ? i_up : r_left;
        min_b = (min_a < r_up_left) ? min_a : r_up_left;
        if (!i_flags.pix_ok) begin
            cur = '0;
        end else if (i_flags.on_border) begin
            cur = SIDE_W'(1);
        end else if (min_b == SIDE_SAT) begin
            cur = SIDE_SAT;
        end else begin
            cur = min_b + SIDE_W'(1);
        end
    end

    // first strict maximum over the frame
    always_comb begin
        better     = cur > r_best;
        n_best     = better ? cur : r_best;
        n_best_col = better ? i_col : r_best_col;
        n_best_row = better ? i_row : r_best_row;
        n_found    = n_best >= i_min_side;
        left_calc  = PW'(n_best_col) + PW'(1) - PW'(n_best);
        top_calc   = PW'(n_best_row) + PW'(1) - PW'(n_best);
    end

    // neighbour and best registers, cleared at the end of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            r_up_left  <= '0;
            r_best     <= '0;
            r_best_col <= '0;
            r_best_row <= '0;
        end else if (fire) begin
            if (i_flags.frame_end) begin
                r_left     <= '0;
                r_up_left  <= '0;
                r_best     <= '0;
                r_best_col <= '0;
                r_best_row <= '0;
            end else begin
                r_left     <= cur;
                r_up_left  <= i_up;
                r_best     <= n_best;
                r_best_col <= n_best_col;
                r_best_row <= n_best_row;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && i_flags.frame_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_flags.frame_end) begin
            r_found <= n_found;
            r_side  <= n_best;
            if (n_found && (n_best != '0)) begin
                r_left_x <= left_calc[COORD_W-1:0];
                r_top_y  <= top_calc[COORD_W-1:0];
            end else begin
                r_left_x <= '0;
                r_top_y  <= '0;
            end
        end
    end

    assign o_wr_en     = fire;
    assign o_wr_addr   = i_col;
    assign o_wr_data   = cur;
    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_left_x    = r_left_x;
    assign o_top_y     = r_top_y;
    assign o_side      = r_side;

endmodule

@@ rtl/largest_valid_square_finder_unit.sv @@
// Largest valid square finder, top level.
// Pixels enter on the s_ stream in raster order, one 8-bit gray value per item;
// a pixel counts when it is above valid_threshold. Per pixel the side of the
// largest square of counted pixels ending there is formed from the row above
// (a line buffer ram), the left and the up-left sides, and the first strict
// maximum is kept with its position. After the frame's last pixel one item
// leaves on the m_ stream: found, left_x, top_y and side.
// Throughput: one pixel per cycle unless a waiting result stalls; the line buffer
// is read at the scan stage and written back at the update stage, behind the
// stage register, with forwarding between them. The result register loads when
// the frame's last pixel passes the update stage.
// A waiting result does not stop the stream; only the next frame's last pixel
// waits for it, so s_tready drops only while m_tready holds a result back.
// Reset restores the registers to 640 x 480, threshold 1, min side 20 and
// starts a new frame; the line buffer needs no clearing pass, a fill count
// makes entries not yet written read as zero.
// Registers must be written via i_cfg_we/i_cfg_idx/i_cfg_wdata only while the
// block is idle, which is not enforced; geometry applies from the next pixel.
`include "largest_valid_square_finder_unit_assert.svh"

module largest_valid_square_finder_unit
    import lvsf_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // pixel stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] pixel_gray
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [0] found, [11:1] left_x,
                                              // [22:12] top_y, [34:23] side,
                                              // [39:35] zero
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    logic [XW:0]          width;
    logic [YW:0]          height;
    logic [CFG_THR_W-1:0] threshold;
    logic [SIDE_W-1:0]    min_side;
    logic                 stall;
    logic                 rd_en;
    logic [XW-1:0]        rd_addr;
    logic                 s1_valid;
    logic [XW-1:0]        s1_col;
    logic [YW-1:0]        s1_row;
    t_pix_flags           s1_flags;
    logic [SIDE_W-1:0]    up;
    logic                 wr_en;
    logic [XW-1:0]        wr_addr;
    logic [SIDE_W-1:0]    wr_data;
    logic                 found;
    logic [COORD_W-1:0]   left_x;
    logic [COORD_W-1:0]   top_y;
    logic [SIDE_W-1:0]    side;

    // configuration registers
    lvsf_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_width     (width),
        .o_height    (height),
        .o_threshold (threshold),
        .o_min_side  (min_side)
    );

    // scan stage
    lvsf_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (s_tvalid),
        .o_pix_ready (s_tready),
        .i_pix_gray  (s_tdata[GRAY_W-1:0]),
        .i_width     (width),
        .i_height    (height),
        .i_threshold (threshold),
        .i_stall     (stall),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_valid     (s1_valid),
        .o_col       (s1_col),
        .o_row       (s1_row),
        .o_flags     (s1_flags)
    );

    // line buffer
    lvsf_lbuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lbuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_up      (up)
    );

    // update stage and result register
    lvsf_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s1_valid),
        .i_col       (s1_col),
        .i_row       (s1_row),
        .i_flags     (s1_flags),
        .i_up        (up),
        .i_min_side  (min_side),
        .o_stall     (stall),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .i_out_ready (m_tready),
        .o_out_valid (m_tvalid),
        .o_found     (found),
        .o_left_x    (left_x),
        .o_top_y     (top_y),
        .o_side      (side)
    );

    // result packing
    assign m_tdata = {{OUT_PAD_W{1'b0}}, side, top_y, left_x, found};

    // checks
    `LVSF_ASSERT(a_stall_cause, i_clk, i_rst_n, !s_tready,
        m_tvalid && !m_tready && s1_valid && s1_flags.frame_end, "input held without cause")
    `LVSF_ASSERT_NEXT(a_frame_end_result, i_clk, i_rst_n,
        s1_valid && s1_flags.frame_end && !stall, m_tvalid, "frame end gave no result")
    `LVSF_ASSERT(a_found_side, i_clk, i_rst_n, m_tvalid && found,
        side >= min_side, "found with side below minimum")
    `LVSF_ASSERT(a_not_found_origin, i_clk, i_rst_n, m_tvalid && !found,
        left_x == '0 && top_y == '0, "position set without a find")

endmodule

@@ verif/tb.sv @@
// testbench for the largest valid square finder: random frames checked against a local scan model
`timescale 1ns / 100ps

module tb;
    import lvsf_pkg::*;

    localparam int FRAME_MAX   = 2048;
    localparam int CYCLE_LIMIT = 40000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 1500;

    // one result item of the block
    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] left_x;
        logic [COORD_W-1:0] top_y;
        logic [SIDE_W-1:0]  side;
    } square_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [7:0] pixel_gray
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // [0] found, [11:1] left_x, [22:12] top_y,
                                            // [34:23] side, [39:35] zero

    // stimulus bookkeeping
    logic [GRAY_W-1:0] pixel_queue[$];
    square_t           expected_squares[$];
    int                pixels_queued = 0;
    int                pixels_taken = 0;
    logic              pixel_taken_now = 1'b0;
    int                idle_pct = 12;
    int                cycle_count = 0;
    logic              failed = 1'b0;

    // local copy of the registers and the scan state
    logic [CFG_DIM_W-1:0] width_reg, height_reg, min_side_reg;
    logic [CFG_THR_W-1:0] thr_reg;
    logic [SIDE_W-1:0]    above_sides [FRAME_MAX];
    logic [SIDE_W-1:0]    left_sq, up_left_sq, best_sq;
    logic [COORD_W-1:0]   col_pos, row_pos, best_row, best_col;

    largest_valid_square_finder_unit #(
        .MAX_WIDTH  (FRAME_MAX),
        .MAX_HEIGHT (FRAME_MAX)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // a zero width or height acts as one, anything above the maximum as the maximum
    function automatic int eff_dim(input logic [CFG_DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > FRAME_MAX) return FRAME_MAX;
        return int'(v);
    endfunction

    // forget the frame, keep the line of sides above
    function automatic void restart_frame();
        left_sq = '0;
        up_left_sq = '0;
        col_pos = '0;
        row_pos = '0;
        best_sq = '0;
        best_row = '0;
        best_col = '0;
    endfunction

    // one pixel through the square scan; queues the frame result at its last pixel
    function automatic void scan_pixel(input logic [GRAY_W-1:0] gray);
        int      w, h, c, r, up, cur, lx, ty;
        square_t res;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        c = int'(col_pos);
        r = int'(row_pos);
        up = int'(above_sides[c]);
        cur = 0;
        if (gray > thr_reg) begin
            if (r == 0 || c == 0) begin
                cur = 1;
            end else begin
                cur = (up < int'(left_sq)) ? up : int'(left_sq);
                if (int'(up_left_sq) < cur) cur = int'(up_left_sq);
                cur = (cur >= int'(SIDE_SAT)) ? int'(SIDE_SAT) : cur + 1;
            end
            if (cur > int'(best_sq)) begin
                best_sq = cur[SIDE_W-1:0];
                best_row = r[COORD_W-1:0];
                best_col = c[COORD_W-1:0];
            end
        end
        up_left_sq = up[SIDE_W-1:0];
        left_sq = cur[SIDE_W-1:0];
        above_sides[c] = cur[SIDE_W-1:0];
        if (c + 1 < w) begin
            col_pos = COORD_W'(c + 1);
        end else begin
            col_pos = '0;
            if (r + 1 < h) begin
                row_pos = COORD_W'(r + 1);
            end else begin
                res.found = (best_sq >= min_side_reg);
                lx = 0;
                ty = 0;
                if (res.found && best_sq > 0) begin
                    lx = int'(best_col) + 1 - int'(best_sq);
                    ty = int'(best_row) + 1 - int'(best_sq);
                end
                res.left_x = lx[COORD_W-1:0];
                res.top_y = ty[COORD_W-1:0];
                res.side = best_sq;
                expected_squares.push_back(res);
                restart_frame();
            end
        end
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    // pixel driver, inputs change on the falling edge
    always @(negedge i_clk) begin
        if (!s_tvalid || pixel_taken_now) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= pixel_queue.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // monitor: register writes, accepted pixels and result items
    always @(posedge i_clk) begin
        square_t want, got;
        pixel_taken_now <= s_tvalid && s_tready;
        if (!i_rst_n) begin
            width_reg = CFG_DIM_W'(RST_FRAME_WIDTH);
            height_reg = CFG_DIM_W'(RST_FRAME_HEIGHT);
            thr_reg = RST_THRESHOLD;
            min_side_reg = RST_MIN_SIDE;
            for (int i = 0; i < FRAME_MAX; i++) above_sides[i] = '0;
            restart_frame();
        end else begin
            if (m_tvalid && m_tready) begin
                got.found = m_tdata[0];
                got.left_x = m_tdata[11:1];
                got.top_y = m_tdata[22:12];
                got.side = m_tdata[34:23];
                if (expected_squares.size() == 0) begin
                    $display("%0t: unexpected result item, expected none got %h", $time,
                             m_tdata);
                    failed = 1'b1;
                end else begin
                    want = expected_squares.pop_front();
                    check_field("found", int'(want.found), int'(got.found));
                    check_field("left_x", int'(want.left_x), int'(got.left_x));
                    check_field("top_y", int'(want.top_y), int'(got.top_y));
                    check_field("side", int'(want.side), int'(got.side));
                    check_field("padding", 0, int'(m_tdata[OUT_TDATA_W-1:OUT_FIELD_W]));
                end
            end
            if (s_tvalid && s_tready) begin
                scan_pixel(s_tdata);
                pixels_taken++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH:     width_reg = i_cfg_wdata;
                    CFG_FRAME_HEIGHT:    height_reg = i_cfg_wdata;
                    CFG_VALID_THRESHOLD: thr_reg = i_cfg_wdata[CFG_THR_W-1:0];
                    CFG_MIN_SIDE:        min_side_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_pixel(input logic [GRAY_W-1:0] gray);
        pixel_queue.push_back(gray);
        pixels_queued++;
    endtask

    // a gray value on the wanted side of the threshold, where one exists
    function automatic logic [GRAY_W-1:0] pick_gray(input bit ok);
        int v;
        if (ok && thr_reg != 8'hFF) v = $urandom_range(255, int'(thr_reg) + 1);
        else v = $urandom_range(int'(thr_reg), 0);
        return v[GRAY_W-1:0];
    endfunction

    // every accepted item answered
    task automatic drain();
        while (!(pixels_taken == pixels_queued && expected_squares.size() == 0))
            @(negedge i_clk);
    endtask

    // drained, then time for a frame still in the pipeline
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(input int w, input int h, input int thr, input int ms);
        settle();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_VALID_THRESHOLD, thr);
        write_reg(CFG_MIN_SIDE, ms);
    endtask

    // pixels from (c0, r0) to the end of the frame, with a random pattern
    task automatic push_frame(input int c0, input int r0);
        int w, h, c, r, mode, rx0, rx1, ry0, ry1;
        bit ok, done;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        c = c0;
        r = r0;
        mode = $urandom_range(19);
        rx0 = $urandom_range(w - 1);
        rx1 = $urandom_range(w - 1, rx0);
        ry0 = $urandom_range(h - 1);
        ry1 = $urandom_range(h - 1, ry0);
        done = 1'b0;
        while (!done) begin
            if (mode < 5) ok = 1'($urandom_range(1));
            else if (mode < 15)
                ok = (c >= rx0 && c <= rx1 && r >= ry0 && r <= ry1) ?
                     ($urandom_range(19) != 0) : ($urandom_range(9) == 0);
            else if (mode < 18) ok = 1'b1;
            else ok = 1'b0;
            push_pixel(pick_gray(ok));
            if (c + 1 < w) begin
                c++;
            end else begin
                c = 0;
                if (r + 1 < h) r++;
                else done = 1'b1;
            end
        end
    endtask

    task automatic random_phase();
        int w, h, frames, k;
        if ($urandom_range(4) != 0) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
        end else begin
            w = $urandom_range(9, 24);
            h = $urandom_range(9, 24);
        end
        if ($urandom_range(19) == 0) w = 0;
        if ($urandom_range(19) == 0) h = 0;
        configure(w, h, $urandom_range(4095), $urandom_range(8));
        frames = $urandom_range(1, 3);
        push_frame(int'(col_pos), int'(row_pos));
        for (int f = 1; f < frames; f++) begin
            if ($urandom_range(4) == 0) drain();
            push_frame(0, 0);
        end
        // now and then leave a frame open across the next geometry change
        if ($urandom_range(6) == 0) begin
            k = $urandom_range(1, eff_dim(width_reg) * eff_dim(height_reg));
            repeat (k) push_pixel(pick_gray(1'($urandom_range(1))));
        end
    endtask

    initial begin
        int directed_end;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // geometry only, threshold and min side left at their reset values
        settle();
        write_reg(CFG_FRAME_WIDTH, 2);
        write_reg(CFG_FRAME_HEIGHT, 2);
        push_pixel(8'd1);
        push_pixel(8'd2);
        push_pixel(8'd0);
        push_pixel(8'd255);

        // full 3 x 3 square, threshold zero
        configure(3, 3, 0, 3);
        push_pixel(8'd255);
        push_pixel(8'd1);
        push_pixel(8'd128);
        push_pixel(8'd64);
        push_pixel(8'd255);
        push_pixel(8'd1);
        push_pixel(8'd200);
        push_pixel(8'd2);
        push_pixel(8'd255);

        // nothing can pass threshold 255, min side zero still reports found
        configure(2, 1, 12'h3FF, 0);
        push_pixel(8'd255);
        push_pixel(8'd0);

        // width shrinks in the middle of the second row
        configure(4, 4, 0, 1);
        repeat (6) push_pixel(8'd9);
        settle();
        write_reg(CFG_FRAME_WIDTH, 2);
        push_frame(int'(col_pos), int'(row_pos));

        // largest min side
        configure(2, 2, 0, 4095);
        push_frame(0, 0);

        // zero geometry acts as a single pixel
        configure(0, 0, 254, 0);
        push_pixel(8'd255);
        push_pixel(8'd254);

        directed_end = pixels_queued;
        for (int phase_no = 0; pixels_queued - directed_end < RANDOM_PIXELS; phase_no++) begin
            idle_pct = (phase_no >= 6 && phase_no < 16) ? 0 : 12;
            random_phase();
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (!failed && expected_squares.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ largest_valid_square_finder_unit.f @@
+incdir+rtl
rtl/lvsf_pkg.sv
rtl/lvsf_ram.sv
rtl/lvsf_cfg.sv
rtl/lvsf_scan.sv
rtl/lvsf_lbuf.sv
rtl/lvsf_dp.sv
rtl/largest_valid_square_finder_unit.sv
verif/tb.sv
